/* sv/shaped_negative_feedback_assert.svh */
// Assertion macros for the shaped negative feedback block.
`ifndef SHAPED_NEGATIVE_FEEDBACK_ASSERT_SVH
`define SHAPED_NEGATIVE_FEEDBACK_ASSERT_SVH
`ifndef SYNTHESIS
`define SNF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("shaped_negative_feedback: assertion failed");
`define SNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("shaped_negative_feedback: assertion failed");
`else
`define SNF_ASSERT(lbl, clk, rstn, prop)
`define SNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/snf_pkg.sv */
package snf_pkg;

  localparam int SAMPLE_BITS = 24;
  // datapath width: holds the feedback sum, which can reach about 1.6x full scale
  localparam int AW          = SAMPLE_BITS + 2;
  localparam int GAIN_W      = 16;
  // product of an AW operand and a zero-extended gain
  localparam int PW          = AW + GAIN_W + 1;
  localparam int FRAC        = 15;
  localparam int ROUND_HALF  = 1 << (FRAC - 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [GAIN_W-1:0] Q15_ONE     = 16'd32768;
  localparam logic [GAIN_W-1:0] K_PRESENCE  = 16'd26214;
  localparam logic [GAIN_W-1:0] K_RESONANCE = 16'd19661;
  localparam logic [GAIN_W-1:0] K_NFB       = 16'd9830;

  localparam logic [GAIN_W-1:0] PRES_POLE_RST = 16'd13357;
  localparam logic [GAIN_W-1:0] RES_POLE_RST  = 16'd384;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [AW-1:0] SAT_MAX =
    {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN =
    {{(AW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRES_LEVEL = 2'd0,
    CFG_RES_LEVEL  = 2'd1,
    CFG_PRES_POLE  = 2'd2,
    CFG_RES_POLE   = 2'd3
  } cfg_idx_t;

  // one code per multiply of the sample
  typedef enum logic [2:0] {
    OP_PLP,   // presence lowpass update
    OP_RLP,   // resonance lowpass update
    OP_HI,    // high band times presence level
    OP_HIK,   // times 0.8, starts feedback sum
    OP_LO,    // low band times resonance level
    OP_LOK,   // times 0.6, subtracted from feedback
    OP_NFB    // feedback times 0.3, output
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLP_M, ST_PLP_A,
    ST_RLP_M, ST_RLP_A,
    ST_HI_M,  ST_HI_A,
    ST_HIK_M, ST_HIK_A,
    ST_LO_M,  ST_LO_A,
    ST_LOK_M, ST_LOK_A,
    ST_NFB_M, ST_NFB_A
  } st_t;

  typedef struct packed {
    op_t  op;
    logic issue;   // load the product register
    logic commit;  // write the rounded product back
    logic idle;
  } ctrl_t;

  function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] g);
    return (g > Q15_ONE) ? Q15_ONE : g;
  endfunction

endpackage

/* sv/snf_mul.sv */
module snf_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [snf_pkg::AW-1:0] a,
  input  logic [snf_pkg::GAIN_W-1:0]   b,
  output logic signed [snf_pkg::AW-1:0] q
);
  import snf_pkg::*;

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] rsum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(a) * PW'($signed({1'b0, b}));
    end
  end

  // Q1.15 scale back, round half up
  assign rsum = prod_r + PW'(ROUND_HALF);
  assign q    = rsum[AW+FRAC-1:FRAC];

endmodule

/* sv/snf_seq.sv */
module snf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_free,
  output snf_pkg::ctrl_t ctrl
);
  import snf_pkg::*;

  st_t state_r;
  st_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_PLP_M;
      ST_PLP_M: state_nxt = ST_PLP_A;
      ST_PLP_A: state_nxt = ST_RLP_M;
      ST_RLP_M: state_nxt = ST_RLP_A;
      ST_RLP_A: state_nxt = ST_HI_M;
      ST_HI_M:  state_nxt = ST_HI_A;
      ST_HI_A:  state_nxt = ST_HIK_M;
      ST_HIK_M: state_nxt = ST_HIK_A;
      ST_HIK_A: state_nxt = ST_LO_M;
      ST_LO_M:  state_nxt = ST_LO_A;
      ST_LO_A:  state_nxt = ST_LOK_M;
      ST_LOK_M: state_nxt = ST_LOK_A;
      ST_LOK_A: state_nxt = ST_NFB_M;
      ST_NFB_M: state_nxt = ST_NFB_A;
      ST_NFB_A: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op     = OP_PLP;
    ctrl.issue  = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.idle   = 1'b0;
    unique case (state_r)
      ST_IDLE:  ctrl.idle = 1'b1;
      ST_PLP_M: begin ctrl.op = OP_PLP; ctrl.issue  = 1'b1; end
      ST_PLP_A: begin ctrl.op = OP_PLP; ctrl.commit = 1'b1; end
      ST_RLP_M: begin ctrl.op = OP_RLP; ctrl.issue  = 1'b1; end
      ST_RLP_A: begin ctrl.op = OP_RLP; ctrl.commit = 1'b1; end
      ST_HI_M:  begin ctrl.op = OP_HI;  ctrl.issue  = 1'b1; end
      ST_HI_A:  begin ctrl.op = OP_HI;  ctrl.commit = 1'b1; end
      ST_HIK_M: begin ctrl.op = OP_HIK; ctrl.issue  = 1'b1; end
      ST_HIK_A: begin ctrl.op = OP_HIK; ctrl.commit = 1'b1; end
      ST_LO_M:  begin ctrl.op = OP_LO;  ctrl.issue  = 1'b1; end
      ST_LO_A:  begin ctrl.op = OP_LO;  ctrl.commit = 1'b1; end
      ST_LOK_M: begin ctrl.op = OP_LOK; ctrl.issue  = 1'b1; end
      ST_LOK_A: begin ctrl.op = OP_LOK; ctrl.commit = 1'b1; end
      ST_NFB_M: begin ctrl.op = OP_NFB; ctrl.issue  = 1'b1; end
      // hold the result until the output register can take it
      ST_NFB_A: begin ctrl.op = OP_NFB; ctrl.commit = out_free; end
      default:  ctrl.idle = 1'b0;
    endcase
  end

endmodule

/* sv/shaped_negative_feedback.sv */
// Channel | Ports                                   | Word
// in      | in_valid, in_ready, in_sample_in        | one input sample, Q4.20
// out     | out_valid, out_ready, out_sample_out,   | output sample, saturated,
//         | out_clipped                             | with clip flag
// cfg     | cfg_valid, cfg_ready, cfg_index,        | level / pole register write
//         | cfg_data                                |
//
// One sample passes through the accept step plus seven multiplies through the
// shared multiplier, each loading the product register and then writing back.
// in_ready is high only while the sequencer is idle; cfg_ready is always high.
// A finished sample sits in the output register; the next sample is taken
// meanwhile and stalls only on its last step if that register is still full.
// Synchronous active-low reset clears filters, prev output, levels; sets poles.
`include "shaped_negative_feedback_assert.svh"

module shaped_negative_feedback (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [snf_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [snf_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [snf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [snf_pkg::GAIN_W-1:0]             cfg_data
);
  import snf_pkg::*;

  localparam int SB = SAMPLE_BITS;

  ctrl_t ctrl;

  logic in_fire;
  logic cfg_fire;
  logic out_free;

  logic [GAIN_W-1:0] pres_level_r;
  logic [GAIN_W-1:0] res_level_r;
  logic [GAIN_W-1:0] pres_pole_r;
  logic [GAIN_W-1:0] res_pole_r;

  logic signed [SB-1:0] x_r,    x_nxt;
  logic signed [SB-1:0] prev_r, prev_nxt;
  logic signed [SB-1:0] plp_r,  plp_nxt;
  logic signed [SB-1:0] rlp_r,  rlp_nxt;
  logic signed [AW-1:0] t_r,    t_nxt;
  logic signed [AW-1:0] fb_r,   fb_nxt;
  logic signed [SB-1:0] out_sample_r,  out_sample_nxt;
  logic                 out_clipped_r, out_clipped_nxt;
  logic                 out_valid_r,   out_valid_nxt;

  logic signed [AW-1:0] mul_a;
  logic [GAIN_W-1:0]    mul_b;
  logic signed [AW-1:0] mul_q;

  logic signed [AW-1:0] x_x, prev_x, plp_x, rlp_x;
  logic signed [AW-1:0] y;
  logic signed [SB-1:0] y_sat;
  logic                 y_clip;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || out_ready;

  assign in_ready       = ctrl.idle;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

  snf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  snf_mul u_mul (
    .clk (clk),
    .en  (ctrl.issue),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  assign x_x    = AW'(x_r);
  assign prev_x = AW'(prev_r);
  assign plp_x  = AW'(plp_r);
  assign rlp_x  = AW'(rlp_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = fb_r;
    mul_b = K_NFB;
    unique case (ctrl.op)
      OP_PLP: begin mul_a = prev_x - plp_x; mul_b = gain_clamp(pres_pole_r);  end
      OP_RLP: begin mul_a = prev_x - rlp_x; mul_b = gain_clamp(res_pole_r);   end
      OP_HI:  begin mul_a = prev_x - plp_x; mul_b = gain_clamp(pres_level_r); end
      OP_HIK: begin mul_a = t_r;            mul_b = K_PRESENCE;               end
      OP_LO:  begin mul_a = rlp_x;          mul_b = gain_clamp(res_level_r);  end
      OP_LOK: begin mul_a = t_r;            mul_b = K_RESONANCE;              end
      OP_NFB: begin mul_a = fb_r;           mul_b = K_NFB;                    end
      default: begin mul_a = fb_r;          mul_b = K_NFB;                    end
    endcase
  end

  assign y = x_x - mul_q;

  always_comb begin
    y_sat  = y[SB-1:0];
    y_clip = 1'b0;
    priority if (y > SAT_MAX) begin
      y_sat  = SAMPLE_MAX;
      y_clip = 1'b1;
    end else if (y < SAT_MIN) begin
      y_sat  = SAMPLE_MIN;
      y_clip = 1'b1;
    end else begin
      y_clip = 1'b0;
    end
  end

  always_comb begin
    x_nxt           = x_r;
    prev_nxt        = prev_r;
    plp_nxt         = plp_r;
    rlp_nxt         = rlp_r;
    t_nxt           = t_r;
    fb_nxt          = fb_r;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (in_fire) begin
      x_nxt = in_sample_in;
    end
    if (ctrl.commit) begin
      unique case (ctrl.op)
        OP_PLP: plp_nxt = SB'(plp_x + mul_q);
        OP_RLP: rlp_nxt = SB'(rlp_x + mul_q);
        OP_HI:  t_nxt   = mul_q;
        OP_HIK: fb_nxt  = prev_x - mul_q;
        OP_LO:  t_nxt   = mul_q;
        OP_LOK: fb_nxt  = fb_r - mul_q;
        OP_NFB: begin
          prev_nxt        = y_sat;
          out_sample_nxt  = y_sat;
          out_clipped_nxt = y_clip;
          out_valid_nxt   = 1'b1;
        end
        default: fb_nxt = fb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      plp_r        <= '0;
      rlp_r        <= '0;
      out_valid_r  <= 1'b0;
      pres_level_r <= '0;
      res_level_r  <= '0;
      pres_pole_r  <= PRES_POLE_RST;
      res_pole_r   <= RES_POLE_RST;
    end else begin
      prev_r      <= prev_nxt;
      plp_r       <= plp_nxt;
      rlp_r       <= rlp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PRES_LEVEL: pres_level_r <= cfg_data;
          CFG_RES_LEVEL:  res_level_r  <= cfg_data;
          CFG_PRES_POLE:  pres_pole_r  <= cfg_data;
          CFG_RES_POLE:   res_pole_r   <= cfg_data;
          default:        res_pole_r   <= res_pole_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    t_r           <= t_nxt;
    fb_r          <= fb_nxt;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  `SNF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `SNF_ASSERT(a_out_from_commit, clk, rst_n, $rose(out_valid) |-> $past(ctrl.commit && (ctrl.op == OP_NFB)))
  `SNF_ASSERT(a_no_overwrite, clk, rst_n, (ctrl.commit && (ctrl.op == OP_NFB)) |-> (!out_valid || out_ready))
  `SNF_ASSERT(a_clip_at_limit, clk, rst_n, (out_valid && out_clipped) |-> ((out_sample_out == SAMPLE_MAX) || (out_sample_out == SAMPLE_MIN)))

endmodule
